### rtl/core/ldts_pkg.sv
// Shared types, constants and helpers for the LCD dot timing sequencer.
`timescale 1ns / 1ps

package ldts_pkg;

  // Line and dot timing of the display.
  localparam logic [7:0] LastLine      = 8'd153;
  localparam logic [7:0] VblankFirst   = 8'd144;
  localparam logic [8:0] DotsPerLine   = 9'd456;
  localparam logic [8:0] OamDots       = 9'd80;
  localparam logic [8:0] DrawDots      = 9'd160;
  localparam logic [4:0] FifoDelay     = 5'd12;
  localparam logic [8:0] ResetDotsLeft = 9'd167;
  localparam logic [8:0] WindowXOffset = 9'd7;

  // Mode codes as presented on the result channel.
  localparam logic [1:0] LcdModeHblank = 2'b00;
  localparam logic [1:0] LcdModeVblank = 2'b01;
  localparam logic [1:0] LcdModeOam    = 2'b10;
  localparam logic [1:0] LcdModeDraw   = 2'b11;

  typedef enum logic [3:0] {
    ModeHblank = 4'b0001,
    ModeVblank = 4'b0010,
    ModeOam    = 4'b0100,
    ModeDraw   = 4'b1000
  } mode_e;

  typedef enum logic [2:0] {
    RegDisplayControl = 3'd0,
    RegStatSelect     = 3'd1,
    RegLineCompare    = 3'd2,
    RegScrollX        = 3'd3,
    RegWindowX        = 3'd4,
    RegWindowY        = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0] display_control;
    logic [3:0] stat_select;
    logic [7:0] line_compare;
    logic [7:0] scroll_x;
    logic [7:0] window_x;
    logic [7:0] window_y;
  } cfg_t;

  typedef struct packed {
    logic [7:0] line_count;
    mode_e      mode;
    logic [8:0] dots_left;
    logic [8:0] dots_in_line;
    logic [4:0] start_delay;
    logic [7:0] column_count;
    logic [7:0] window_line;
    logic       match_flag;
  } state_t;

  typedef struct packed {
    logic [1:0] lcd_mode;
    logic [7:0] line_out;
    logic       pixel_valid;
    logic [7:0] pixel_column;
    logic       line_match;
    logic       stat_request;
    logic       vblank_request;
    logic [7:0] window_line_out;
  } result_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] code;
    unique case (m)
      ModeHblank: code = LcdModeHblank;
      ModeVblank: code = LcdModeVblank;
      ModeOam:    code = LcdModeOam;
      ModeDraw:   code = LcdModeDraw;
      default:    code = LcdModeHblank;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/lcd_dot_timing_sequencer.sv
// Top level of the LCD dot timing sequencer: configuration, line state and result buffering.
`timescale 1ns / 1ps

// Usage.
// Each request on the input channel (in_valid_i, in_stall_o, advance_i) is one dot
// tick. With advance_i high and display_control bit 0 set, the line state moves on
// by one dot; otherwise it holds and the result merely reports the current state.
// Every accepted request yields exactly one result request on the output channel
// (out_valid_o, out_stall_i and the result fields), in order.
// Each result is registered, in the result register or else in the skid entry.
// Throughput is one request per cycle while in_stall_o is low, set by the single
// combinational step between the line state registers and the result register.
// The result register is backed by a one-entry skid buffer, so one further request
// is taken while a result waits under stall; in_stall_o rises only once both hold
// a result, and the sequencer then waits for the receiver to drain them.
// Configuration writes (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) are
// always accepted and should be made while the sequencer is idle.
// Indices beyond the register list are ignored.
// Reset puts the display control register to display on, all other registers to
// zero, the line state to line 0 in horizontal blank with 167 dots left, and
// empties both result stages.

module lcd_dot_timing_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // dot tick channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       advance_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] lcd_mode_o,
  output logic [7:0] line_out_o,
  output logic       pixel_valid_o,
  output logic [7:0] pixel_column_o,
  output logic       line_match_o,
  output logic       stat_request_o,
  output logic       vblank_request_o,
  output logic [7:0] window_line_out_o,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import ldts_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t step_res;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  logic    in_fire;
  logic    out_free;

  // Configuration registers: never back-pressured.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.display_control <= 3'd1;
      cfg_q.stat_select     <= '0;
      cfg_q.line_compare    <= '0;
      cfg_q.scroll_x        <= '0;
      cfg_q.window_x        <= '0;
      cfg_q.window_y        <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegDisplayControl: cfg_q.display_control <= cfg_data_i[2:0];
        RegStatSelect:     cfg_q.stat_select     <= cfg_data_i[3:0];
        RegLineCompare:    cfg_q.line_compare    <= cfg_data_i;
        RegScrollX:        cfg_q.scroll_x        <= cfg_data_i;
        RegWindowX:        cfg_q.window_x        <= cfg_data_i;
        RegWindowY:        cfg_q.window_y        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One dot of work, all in combinational logic.
  ldts_step u_step (
    .cur_i     (state_q),
    .cfg_i     (cfg_q),
    .advance_i (advance_i),
    .nxt_o     (state_d),
    .res_o     (step_res)
  );

  // The input is held off only once the skid entry is occupied, so the stall
  // never depends combinationally on the receiver.
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i & ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.line_count   <= '0;
      state_q.mode         <= ModeHblank;
      state_q.dots_left    <= ResetDotsLeft;
      state_q.dots_in_line <= '0;
      state_q.start_delay  <= '0;
      state_q.column_count <= '0;
      state_q.window_line  <= '0;
      state_q.match_flag   <= 1'b0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // The output register takes a new result whenever it is empty or being read;
  // a waiting skid entry goes first. Otherwise a fresh result parks in the skid.
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = step_res;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = step_res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o       = out_valid_q;
  assign lcd_mode_o        = out_q.lcd_mode;
  assign line_out_o        = out_q.line_out;
  assign pixel_valid_o     = out_q.pixel_valid;
  assign pixel_column_o    = out_q.pixel_column;
  assign line_match_o      = out_q.line_match;
  assign stat_request_o    = out_q.stat_request;
  assign vblank_request_o  = out_q.vblank_request;
  assign window_line_out_o = out_q.window_line_out;

endmodule

### rtl/core/ldts_step.sv
// Next-state and result logic for one dot of the LCD timing sequencer.
`timescale 1ns / 1ps

module ldts_step (
  input  ldts_pkg::state_t  cur_i,
  input  ldts_pkg::cfg_t    cfg_i,
  input  logic              advance_i,
  output ldts_pkg::state_t  nxt_o,
  output ldts_pkg::result_t res_o
);
  import ldts_pkg::*;

  state_t     nxt;
  logic       now_match;
  logic       stat_req;
  logic       vbl_req;
  logic       pix_valid;
  logic [7:0] pix_col;

  always_comb begin
    nxt       = cur_i;
    stat_req  = 1'b0;
    vbl_req   = 1'b0;
    pix_valid = 1'b0;
    pix_col   = '0;
    now_match = (cur_i.line_count == cfg_i.line_compare);

    if (advance_i && cfg_i.display_control[0]) begin
      // The match interrupt fires on the rising edge of the flag.
      stat_req = now_match & ~cur_i.match_flag & cfg_i.stat_select[3];
      nxt.match_flag   = now_match;
      nxt.dots_in_line = cur_i.dots_in_line + 9'd1;

      if (cur_i.dots_left == '0) begin
        unique case (cur_i.mode)
          ModeOam: begin
            nxt.mode = ModeDraw;
          end
          ModeDraw: begin
            nxt.mode = ModeHblank;
          end
          default: begin
            nxt.line_count = (cur_i.line_count == LastLine) ? '0 : cur_i.line_count + 8'd1;
            if (nxt.line_count == VblankFirst) begin
              vbl_req  = 1'b1;
              stat_req = cfg_i.stat_select[1] | (now_match & cfg_i.stat_select[3]);
            end
            nxt.mode = (nxt.line_count < VblankFirst) ? ModeOam : ModeVblank;
          end
        endcase

        unique case (nxt.mode)
          ModeOam: begin
            nxt.dots_in_line = '0;
            nxt.dots_left    = OamDots;
            if (cfg_i.stat_select[2]) stat_req = 1'b1;
          end
          ModeDraw: begin
            nxt.start_delay  = cur_i.start_delay + FifoDelay + {2'b00, cfg_i.scroll_x[2:0]};
            nxt.dots_left    = DrawDots + {4'b0000, nxt.start_delay};
            nxt.column_count = '0;
          end
          ModeVblank: begin
            nxt.dots_left    = DotsPerLine;
            nxt.dots_in_line = '0;
            if (nxt.line_count == LastLine) nxt.window_line = '0;
          end
          default: begin
            nxt.dots_left = DotsPerLine - nxt.dots_in_line;
            if (cfg_i.stat_select[0]) stat_req = 1'b1;
            if (cfg_i.display_control[1] && cfg_i.display_control[2] &&
                ({1'b0, cur_i.column_count} + WindowXOffset >= {1'b0, cfg_i.window_x}) &&
                (nxt.line_count >= cfg_i.window_y)) begin
              nxt.window_line = cur_i.window_line + 8'd1;
            end
          end
        endcase
      end

      nxt.dots_left = nxt.dots_left - 9'd1;

      // The first dots of drawing are swallowed by the start delay.
      if (nxt.mode == ModeDraw) begin
        if (nxt.start_delay != '0) begin
          nxt.start_delay = nxt.start_delay - 5'd1;
        end else begin
          pix_valid        = 1'b1;
          pix_col          = nxt.column_count;
          nxt.column_count = nxt.column_count + 8'd1;
        end
      end
    end
  end

  assign nxt_o = nxt;

  always_comb begin
    res_o.lcd_mode        = mode_code(nxt.mode);
    res_o.line_out        = nxt.line_count;
    res_o.pixel_valid     = pix_valid;
    res_o.pixel_column    = pix_col;
    res_o.line_match      = nxt.match_flag;
    res_o.stat_request    = stat_req;
    res_o.vblank_request  = vbl_req;
    res_o.window_line_out = nxt.window_line;
  end

endmodule
